[src/ubds_pkg.sv]
// ---------------------------------------------------------------------------
// ubds_pkg
// Shared constants for the baud divisor search: default search limits and
// the fixed widths of the request and response fields.
// ---------------------------------------------------------------------------
`default_nettype none

package ubds_pkg;

   localparam int UBDS_DIVISOR_LIMIT = 8191;
   localparam int UBDS_RATE_LOW      = 4;
   localparam int UBDS_RATE_HIGH     = 32;

   localparam int UBDS_DATA_W        = 32;
   localparam int UBDS_DIVISOR_W     = 13;
   localparam int UBDS_OVERSAMPLE_W  = 6;

endpackage

`default_nettype wire

[src/uart_baud_divisor_search.sv]
// ---------------------------------------------------------------------------
// uart_baud_divisor_search
// Picks a baud divisor and oversampling rate for a serial unit.
// ---------------------------------------------------------------------------
// Fully pipelined: one request beat is taken every cycle while the
// response is not stalled. The pipeline is made of two 32-stage
// bit-per-cycle dividers (clock over baud, and the clock over each
// candidate rate-times-divisor product), one reciprocal-multiply stage
// that splits the ratio by every oversampling rate, one stage that forms
// the candidate products, and the running best-error compare, which
// takes one oversampling rate per stage. A stalled response freezes the
// whole pipeline.
`default_nettype none

module uart_baud_divisor_search #(
   parameter int DIVISOR_LIMIT = ubds_pkg::UBDS_DIVISOR_LIMIT,
   parameter int RATE_LOW      = ubds_pkg::UBDS_RATE_LOW,
   parameter int RATE_HIGH     = ubds_pkg::UBDS_RATE_HIGH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [ubds_pkg::UBDS_DATA_W-1:0]       req_clock_hz,
   input  logic [ubds_pkg::UBDS_DATA_W-1:0]       req_baud_rate,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [ubds_pkg::UBDS_DIVISOR_W-1:0]    rsp_divisor,
   output logic [ubds_pkg::UBDS_OVERSAMPLE_W-1:0] rsp_oversample,
   output logic [ubds_pkg::UBDS_DATA_W-1:0]       rsp_rate_error,
   output logic                                   rsp_found
);

   import ubds_pkg::*;

   localparam int NR = RATE_HIGH - RATE_LOW;
   localparam int DW = $clog2(DIVISOR_LIMIT + 1);
   localparam int RW = $clog2(RATE_HIGH + 1);
   localparam int PW = DW + RW;
   localparam int CW = UBDS_DATA_W;
   localparam int QW = $clog2(DIVISOR_LIMIT * RATE_HIGH);
   localparam int KS = QW + RW;
   localparam int SW = QW + KS;
   localparam int C_SIDE_W = CW + NR + NR * DW;

   logic advance;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // clock over baud
   logic                   a_valid;
   logic [0:0][CW-1:0]     a_den;
   logic [0:0][CW-1:0]     a_quo;
   logic [2*CW-1:0]        a_side;

   assign a_den[0] = req_baud_rate;

   ubds_div #(.NUM_W(CW), .DEN_W(CW), .LANES(1), .SIDE_W(2 * CW)) u_ratio (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_num    (req_clock_hz),
      .in_den    (a_den),
      .in_side   ({req_clock_hz, req_baud_rate}),
      .out_valid (a_valid),
      .out_quo   (a_quo),
      .out_side  (a_side)
   );

   // ratio over each oversampling rate, by reciprocal multiply
   logic                  b_valid_ff;
   logic [CW-1:0]         b_clock_ff;
   logic [CW-1:0]         b_baud_ff;
   logic [NR-1:0]         b_big_ff;
   logic [NR-1:0][DW-1:0] b_d0_ff;

   logic [NR-1:0]         b_big_in;
   logic [NR-1:0][DW-1:0] b_d0_in;

   for (genvar i = 0; i < NR; i++) begin : g_rate
      localparam int RATE  = RATE_LOW + 1 + i;
      localparam int RECIP = ((1 << KS) + RATE - 1) / RATE;
      logic [SW-1:0] scaled;

      assign scaled      = SW'(a_quo[0][QW-1:0]) * SW'(RECIP);
      assign b_big_in[i] = (a_quo[0] >= CW'(DIVISOR_LIMIT * RATE));
      assign b_d0_in[i]  = scaled[KS +: DW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid;
      end
      if (advance) begin
         b_clock_ff <= a_side[2*CW-1:CW];
         b_baud_ff  <= a_side[CW-1:0];
         b_big_ff   <= b_big_in;
         b_d0_ff    <= b_d0_in;
      end
   end

   // candidate divisors and their products
   logic                  prep_valid_ff;
   logic [CW-1:0]         prep_clock_ff;
   logic [CW-1:0]         prep_baud_ff;
   logic [NR-1:0]         prep_big_ff;
   logic [NR-1:0][DW-1:0] prep_d0_ff;
   logic [NR-1:0][PW-1:0] prep_prod0_ff;
   logic [NR-1:0][PW-1:0] prep_prod1_ff;

   logic [NR-1:0]         prep_big_in;
   logic [NR-1:0][DW-1:0] prep_d0_in;
   logic [NR-1:0][PW-1:0] prep_prod0_in;
   logic [NR-1:0][PW-1:0] prep_prod1_in;

   always_comb begin
      logic [DW-1:0] d1;
      prep_big_in = b_big_ff;
      for (int i = 0; i < NR; i++) begin
         prep_d0_in[i]    = b_d0_ff[i];
         d1               = b_d0_ff[i] + DW'(1);
         prep_prod0_in[i] = PW'(b_d0_ff[i]) * PW'(RATE_LOW + 1 + i);
         prep_prod1_in[i] = PW'(d1) * PW'(RATE_LOW + 1 + i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (advance) begin
         prep_valid_ff <= b_valid_ff;
      end
      if (advance) begin
         prep_clock_ff <= b_clock_ff;
         prep_baud_ff  <= b_baud_ff;
         prep_big_ff   <= prep_big_in;
         prep_d0_ff    <= prep_d0_in;
         prep_prod0_ff <= prep_prod0_in;
         prep_prod1_ff <= prep_prod1_in;
      end
   end

   // achieved rate of every candidate
   logic                      c_valid;
   logic [2*NR-1:0][PW-1:0]   c_den;
   logic [2*NR-1:0][CW-1:0]   c_quo;
   logic [C_SIDE_W-1:0]       c_side;
   logic [CW-1:0]             c_baud;
   logic [NR-1:0]             c_big;
   logic [NR-1:0][DW-1:0]     c_d0;

   for (genvar i = 0; i < NR; i++) begin : g_cand
      assign c_den[2*i]   = prep_prod0_ff[i];
      assign c_den[2*i+1] = prep_prod1_ff[i];
   end

   ubds_div #(.NUM_W(CW), .DEN_W(PW), .LANES(2 * NR), .SIDE_W(C_SIDE_W)) u_achieved (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (prep_valid_ff),
      .in_num    (prep_clock_ff),
      .in_den    (c_den),
      .in_side   ({prep_baud_ff, prep_big_ff, prep_d0_ff}),
      .out_valid (c_valid),
      .out_quo   (c_quo),
      .out_side  (c_side)
   );

   assign c_baud = c_side[C_SIDE_W-1 -: CW];
   assign c_big  = c_side[NR*DW +: NR];
   assign c_d0   = c_side[NR*DW-1:0];

   // pick per rate, then run the best-error chain, one rate per stage
   logic                   ch_valid_ff [NR+1];
   logic [CW-1:0]          ch_be_ff    [NR+1];
   logic [DW-1:0]          ch_bd_ff    [NR+1];
   logic [RW-1:0]          ch_br_ff    [NR+1];
   logic                   ch_found_ff [NR+1];
   logic [NR-1:0][DW-1:0]  ch_cd_ff    [NR+1];
   logic [NR-1:0][CW-1:0]  ch_ce_ff    [NR+1];
   logic [NR-1:0]          ch_ok_ff    [NR+1];

   logic                   ch_valid_in [NR+1];
   logic [CW-1:0]          ch_be_in    [NR+1];
   logic [DW-1:0]          ch_bd_in    [NR+1];
   logic [RW-1:0]          ch_br_in    [NR+1];
   logic                   ch_found_in [NR+1];
   logic [NR-1:0][DW-1:0]  ch_cd_in    [NR+1];
   logic [NR-1:0][CW-1:0]  ch_ce_in    [NR+1];
   logic [NR-1:0]          ch_ok_in    [NR+1];

   logic [NR-1:0][DW-1:0]  pick_d;
   logic [NR-1:0][CW-1:0]  pick_e;
   logic [NR-1:0]          pick_ok;

   always_comb begin
      logic [CW-1:0] g0;
      logic [CW-1:0] g1;
      logic [CW-1:0] e0;
      logic [CW-1:0] e1;
      logic [DW-1:0] d1;
      logic          take1;
      for (int i = 0; i < NR; i++) begin
         g0         = c_quo[2*i];
         g1         = c_quo[2*i+1];
         e0         = (g0 > c_baud) ? (g0 - c_baud) : (c_baud - g0);
         e1         = (g1 > c_baud) ? (g1 - c_baud) : (c_baud - g1);
         d1         = c_d0[i] + DW'(1);
         take1      = (c_d0[i] == '0) || (e1 < e0);
         pick_d[i]  = take1 ? d1 : c_d0[i];
         pick_e[i]  = take1 ? e1 : e0;
         pick_ok[i] = !c_big[i] && (c_baud != '0) && (pick_d[i] < DW'(DIVISOR_LIMIT));
      end
   end

   assign ch_valid_in[0] = c_valid;
   assign ch_be_in[0]    = c_baud;
   assign ch_bd_in[0]    = '0;
   assign ch_br_in[0]    = '0;
   assign ch_found_in[0] = 1'b0;
   assign ch_cd_in[0]    = pick_d;
   assign ch_ce_in[0]    = pick_e;
   assign ch_ok_in[0]    = pick_ok;

   for (genvar k = 0; k < NR; k++) begin : g_chain
      logic take;

      assign take = ch_ok_ff[k][k] && (ch_ce_ff[k][k] <= ch_be_ff[k]);

      assign ch_valid_in[k+1] = ch_valid_ff[k];
      assign ch_be_in[k+1]    = take ? ch_ce_ff[k][k] : ch_be_ff[k];
      assign ch_bd_in[k+1]    = take ? ch_cd_ff[k][k] : ch_bd_ff[k];
      assign ch_br_in[k+1]    = take ? RW'(RATE_LOW + 1 + k) : ch_br_ff[k];
      assign ch_found_in[k+1] = take || ch_found_ff[k];
      assign ch_cd_in[k+1]    = ch_cd_ff[k];
      assign ch_ce_in[k+1]    = ch_ce_ff[k];
      assign ch_ok_in[k+1]    = ch_ok_ff[k];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NR; k++) begin
         if (reset) begin
            ch_valid_ff[k] <= 1'b0;
         end else if (advance) begin
            ch_valid_ff[k] <= ch_valid_in[k];
         end
         if (advance) begin
            ch_be_ff[k]    <= ch_be_in[k];
            ch_bd_ff[k]    <= ch_bd_in[k];
            ch_br_ff[k]    <= ch_br_in[k];
            ch_found_ff[k] <= ch_found_in[k];
            ch_cd_ff[k]    <= ch_cd_in[k];
            ch_ce_ff[k]    <= ch_ce_in[k];
            ch_ok_ff[k]    <= ch_ok_in[k];
         end
      end
   end

   logic [63:0] out_div_wide;
   logic [63:0] out_rate_wide;

   assign out_div_wide   = 64'(ch_bd_ff[NR]);
   assign out_rate_wide  = 64'(ch_br_ff[NR]);

   assign rsp_valid      = ch_valid_ff[NR];
   assign rsp_divisor    = out_div_wide[UBDS_DIVISOR_W-1:0];
   assign rsp_oversample = out_rate_wide[UBDS_OVERSAMPLE_W-1:0];
   assign rsp_rate_error = ch_found_ff[NR] ? ch_be_ff[NR] : '0;
   assign rsp_found      = ch_found_ff[NR];

`ifndef SYNTHESIS
   a_found_divisor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> (rsp_divisor != '0) &&
         (64'(rsp_divisor) < 64'(DIVISOR_LIMIT)))
      else $error("found response with divisor out of range");

   a_found_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> (64'(rsp_oversample) > 64'(RATE_LOW)) &&
         (64'(rsp_oversample) <= 64'(RATE_HIGH)))
      else $error("found response with oversampling rate out of range");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_divisor == '0) && (rsp_oversample == '0) &&
         (rsp_rate_error == '0))
      else $error("empty response carries nonzero fields");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output free");
`endif

endmodule

`default_nettype wire

[src/ubds_div.sv]
// ---------------------------------------------------------------------------
// ubds_div
// Pipelined restoring divider, one quotient bit per stage. One shared
// dividend, one divisor per lane, and a sideband that travels with the beat.
// ---------------------------------------------------------------------------
`default_nettype none

module ubds_div #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 32,
   parameter int LANES  = 1,
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [NUM_W-1:0]              in_num,
   input  logic [LANES-1:0][DEN_W-1:0]   in_den,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [LANES-1:0][NUM_W-1:0]   out_quo,
   output logic [SIDE_W-1:0]             out_side
);

   logic                            valid_ff [NUM_W];
   logic [SIDE_W-1:0]               side_ff  [NUM_W];
   logic [LANES-1:0][DEN_W-1:0]     den_ff   [NUM_W];
   logic [LANES-1:0][DEN_W-1:0]     rem_ff   [NUM_W];
   logic [LANES-1:0][NUM_W-1:0]     work_ff  [NUM_W];

   logic                            valid_in [NUM_W];
   logic [SIDE_W-1:0]               side_in  [NUM_W];
   logic [LANES-1:0][DEN_W-1:0]     den_in   [NUM_W];
   logic [LANES-1:0][DEN_W-1:0]     rem_in   [NUM_W];
   logic [LANES-1:0][NUM_W-1:0]     work_in  [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [LANES-1:0][NUM_W-1:0] src_work;
      logic [LANES-1:0][DEN_W-1:0] src_rem;
      logic [LANES-1:0][NUM_W-1:0] nxt_work;
      logic [LANES-1:0][DEN_W-1:0] nxt_rem;

      if (s == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               src_work[l] = in_num;
               src_rem[l]  = '0;
            end
         end
         assign valid_in[s] = in_valid;
         assign side_in[s]  = in_side;
         assign den_in[s]   = in_den;
      end else begin : g_next
         assign src_work    = work_ff[s-1];
         assign src_rem     = rem_ff[s-1];
         assign valid_in[s] = valid_ff[s-1];
         assign side_in[s]  = side_ff[s-1];
         assign den_in[s]   = den_ff[s-1];
      end

      always_comb begin
         logic [DEN_W:0] trial;
         logic [DEN_W:0] diff;
         logic           ge;
         for (int l = 0; l < LANES; l++) begin
            trial       = {src_rem[l], src_work[l][NUM_W-1]};
            diff        = trial - {1'b0, den_in[s][l]};
            ge          = (trial >= {1'b0, den_in[s][l]});
            nxt_rem[l]  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nxt_work[l] = {src_work[l][NUM_W-2:0], ge};
         end
      end

      assign work_in[s] = nxt_work;
      assign rem_in[s]  = nxt_rem;
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NUM_W; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_in[s];
         end
         if (advance) begin
            side_ff[s] <= side_in[s];
            den_ff[s]  <= den_in[s];
            rem_ff[s]  <= rem_in[s];
            work_ff[s] <= work_in[s];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = work_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

`default_nettype wire
